// ===== design/tffr_pkg.sv =====
// tffr_pkg: shared types, request codes and the 3x5 glyph table
// used by the front, the queue and the back of the tiny font renderer
// no dependencies
package tffr_pkg;

    localparam int GLYPH_W    = 3;
    localparam int GLYPH_H    = 5;
    localparam int GLYPH_BITS = GLYPH_W * GLYPH_H;
    localparam int STORE_COL_W = 8;  // widest store column index (256 columns)

    // request codes
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_DRAW  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    typedef logic [GLYPH_BITS-1:0] t_glyph;  // {col2, col1, col0}, bit 0 top row

    typedef struct packed {
        logic [1:0]             op;
        t_glyph                 glyph;
        logic signed [8:0]      pos_x;
        logic signed [5:0]      pos_y;
        logic                   rd_ok;
        logic [1:0]             rd_page;
        logic [STORE_COL_W-1:0] rd_col;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    localparam t_glyph GLYPH_SPACE    = {5'h00, 5'h00, 5'h00};
    localparam t_glyph GLYPH_MINUS    = {5'h04, 5'h04, 5'h04};
    localparam t_glyph GLYPH_PERIOD   = {5'h00, 5'h10, 5'h00};
    localparam t_glyph GLYPH_FALLBACK = {5'h04, 5'h0E, 5'h04};

    localparam t_glyph DIGIT_ROM [10] = '{
        {5'h1F, 5'h11, 5'h1F}, {5'h00, 5'h1F, 5'h00}, {5'h17, 5'h15, 5'h1D},
        {5'h1F, 5'h15, 5'h11}, {5'h1F, 5'h04, 5'h07}, {5'h1D, 5'h15, 5'h17},
        {5'h1D, 5'h15, 5'h1F}, {5'h1F, 5'h01, 5'h01}, {5'h1F, 5'h15, 5'h1F},
        {5'h1F, 5'h15, 5'h17}
    };

    // letter Q loses its sixth row, which is never drawn
    localparam t_glyph LETTER_ROM [26] = '{
        {5'h1F, 5'h05, 5'h1F}, {5'h0A, 5'h15, 5'h1F}, {5'h11, 5'h11, 5'h1F},
        {5'h0E, 5'h11, 5'h1F}, {5'h11, 5'h15, 5'h1F}, {5'h01, 5'h05, 5'h1F},
        {5'h1D, 5'h11, 5'h1F}, {5'h1F, 5'h04, 5'h1F}, {5'h11, 5'h1F, 5'h11},
        {5'h0F, 5'h10, 5'h10}, {5'h1B, 5'h04, 5'h1F}, {5'h10, 5'h10, 5'h1F},
        {5'h1F, 5'h06, 5'h1F}, {5'h1F, 5'h02, 5'h1F}, {5'h1F, 5'h11, 5'h1F},
        {5'h03, 5'h05, 5'h1F}, {5'h0F, 5'h11, 5'h1F}, {5'h16, 5'h0D, 5'h1F},
        {5'h1D, 5'h15, 5'h17}, {5'h01, 5'h1F, 5'h01}, {5'h1F, 5'h10, 5'h0F},
        {5'h07, 5'h18, 5'h07}, {5'h1F, 5'h0C, 5'h1F}, {5'h1B, 5'h04, 5'h1B},
        {5'h03, 5'h1C, 5'h03}, {5'h13, 5'h15, 5'h19}
    };

    function automatic t_glyph glyph_for(input logic [7:0] code);
        t_glyph g;
        unique case (code) inside
            8'h20:          g = GLYPH_SPACE;
            [8'h30:8'h39]:  g = DIGIT_ROM[4'(code - 8'h30)];
            [8'h41:8'h5A]:  g = LETTER_ROM[5'(code - 8'h41)];
            [8'h61:8'h7A]:  g = LETTER_ROM[5'(code - 8'h61)];
            8'h2D:          g = GLYPH_MINUS;
            8'h2E:          g = GLYPH_PERIOD;
            default:        g = GLYPH_FALLBACK;
        endcase
        return g;
    endfunction

endpackage

// ===== design/tffr_ram.sv =====
// tffr_ram: generic simple dual port ram, one write and one read port
// read data registered; no dependencies
module tffr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/tffr_queue.sv =====
// tffr_queue: two entry command queue between front and back
// depends on tffr_pkg for the command and status types
module tffr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tffr_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output tffr_pkg::t_cmd o_cmd,
    output tffr_pkg::t_q_stat o_stat
);
    import tffr_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = ~r_wp;
        end
        if (i_pop) begin
            n_rp = ~r_rp;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    assign o_cmd        = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

endmodule

// ===== design/tffr_front.sv =====
// tffr_front: takes requests, classifies them and builds queue commands
// (glyph lookup, mirrored read column, range checks); depends on tffr_pkg
module tffr_front #(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic [1:0]        i_req_type,
    input  logic [7:0]        i_char_code,
    input  logic signed [8:0] i_pos_x,
    input  logic signed [5:0] i_pos_y,
    input  logic [1:0]        i_read_page,
    input  logic [6:0]        i_read_column,
    input  tffr_pkg::t_q_stat i_q_stat,
    input  logic              i_init,
    output logic              o_push,
    output tffr_pkg::t_cmd    o_cmd
);
    import tffr_pkg::*;

    localparam int PAGES = (DISPLAY_HEIGHT + 7) / 8;

    logic       r_mirror;
    logic [8:0] col_plain;
    logic [8:0] col_store;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror <= 1'b1;
        end else if (i_cfg_we) begin
            r_mirror <= i_cfg_wdata;
        end
    end

    assign col_plain = {2'b00, i_read_column};
    assign col_store = r_mirror ? (9'(DISPLAY_WIDTH - 1) - col_plain) : col_plain;

    always_comb begin
        o_cmd.op      = REQ_NONE;
        o_cmd.glyph   = glyph_for(i_char_code);
        o_cmd.pos_x   = i_pos_x;
        o_cmd.pos_y   = i_pos_y;
        o_cmd.rd_ok   = (col_plain < 9'(DISPLAY_WIDTH)) &&
                        ({2'b00, i_read_page} < 4'(PAGES));
        o_cmd.rd_page = i_read_page;
        o_cmd.rd_col  = col_store[STORE_COL_W-1:0];
        unique case (i_req_type)
            REQ_CLEAR: o_cmd.op = REQ_CLEAR;
            REQ_DRAW:  o_cmd.op = REQ_DRAW;
            REQ_READ:  o_cmd.op = REQ_READ;
            REQ_NONE:  o_cmd.op = REQ_NONE;
        endcase
    end

    assign o_busy = i_q_stat.full || i_init;
    assign o_push = i_start && !o_busy;

endmodule

// ===== design/tffr_back.sv =====
// tffr_back: executes queued commands against the page organized frame store
// clear sweep, pipelined glyph read-modify-write, byte read; depends on tffr_pkg, tffr_ram
module tffr_back #(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tffr_pkg::t_cmd    i_cmd,
    input  tffr_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    output logic              o_init,
    output logic              o_done,
    output logic [7:0]        o_read_data
);
    import tffr_pkg::*;

    localparam int PAGES     = (DISPLAY_HEIGHT + 7) / 8;
    localparam int DEPTH     = DISPLAY_WIDTH * PAGES;
    localparam int AW        = $clog2(DEPTH);
    localparam int LAST_ROWS = DISPLAY_HEIGHT - 8 * (PAGES - 1);
    localparam logic [7:0] LAST_MASK = 8'((16'd1 << LAST_ROWS) - 16'd1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [2:0] SLOTS = 3'(2 * GLYPH_W);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CLEAR  = 3'd1;
    localparam logic [2:0] ST_DRAW   = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_RDWAIT = 3'd4;

    typedef struct packed {
        logic          ok;
        logic [7:0]    bits;
        logic [AW-1:0] addr;
    } t_slot;

    // slot k covers glyph column k/2 and the upper (even) or lower (odd) page
    function automatic t_slot slot_info(input logic [2:0] k, input t_cmd cmd);
        t_slot             s;
        logic [1:0]        col;
        logic signed [9:0] x;
        logic signed [3:0] pg;
        logic [4:0]        gcol;
        logic [15:0]       wide;
        col  = k[2:1];
        x    = {cmd.pos_x[8], cmd.pos_x} + 10'(col);
        pg   = {cmd.pos_y[5], cmd.pos_y[5:3]} + {3'b000, k[0]};
        gcol = cmd.glyph[GLYPH_H * col +: GLYPH_H];
        wide = {11'd0, gcol} << cmd.pos_y[2:0];
        s.bits = k[0] ? wide[15:8] : wide[7:0];
        if ({1'b0, pg[2:0]} == 4'(PAGES - 1)) begin
            s.bits = s.bits & LAST_MASK;
        end
        s.ok   = !x[9] && (x < 10'(DISPLAY_WIDTH)) &&
                 !pg[3] && ({1'b0, pg[2:0]} < 4'(PAGES));
        s.addr = AW'(32'(pg[2:0]) * 32'(DISPLAY_WIDTH) + 32'(x[7:0]));
        return s;
    endfunction

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [2:0]    r_slot, n_slot;
    logic          r_init, n_init;
    logic          r_done, n_done;
    logic [7:0]    r_data, n_data;
    t_cmd          r_cmd, n_cmd;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic [AW-1:0] rd_addr;
    logic [2:0]    rslot_idx;
    logic [2:0]    wslot_idx;
    t_slot         rs;
    t_slot         ws;

    tffr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_addr   = AW'(32'(r_cmd.rd_page) * 32'(DISPLAY_WIDTH) + 32'(r_cmd.rd_col));
    assign rslot_idx = (r_slot == SLOTS) ? 3'd0 : r_slot;
    assign wslot_idx = (r_slot == 3'd0) ? 3'd0 : r_slot - 3'd1;
    assign rs        = slot_info(rslot_idx, r_cmd);
    assign ws        = slot_info(wslot_idx, r_cmd);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_slot    = r_slot;
        n_init    = r_init;
        n_done    = 1'b0;
        n_data    = 8'h00;
        n_cmd     = r_cmd;
        o_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_cnt;
        ram_wdata = 8'h00;
        ram_raddr = rd_addr;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    unique case (i_cmd.op)
                        REQ_CLEAR: begin
                            n_state = ST_CLEAR;
                            n_cnt   = '0;
                        end
                        REQ_DRAW: begin
                            n_state = ST_DRAW;
                            n_slot  = 3'd0;
                        end
                        REQ_READ: n_state = ST_READ;
                        REQ_NONE: n_done  = 1'b1;
                    endcase
                end
            end
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                if (r_cnt == LAST_ADDR) begin
                    n_state = ST_IDLE;
                    n_init  = 1'b0;
                    n_done  = !r_init;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            ST_DRAW: begin
                ram_raddr = rs.addr;
                if (r_slot != 3'd0) begin
                    ram_we    = ws.ok;
                    ram_waddr = ws.addr;
                    ram_wdata = ram_rdata | ws.bits;
                end
                if (r_slot == SLOTS) begin
                    n_state = ST_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_slot = r_slot + 3'd1;
                end
            end
            ST_READ: begin
                n_state = ST_RDWAIT;
            end
            ST_RDWAIT: begin
                n_done  = 1'b1;
                n_data  = r_cmd.rd_ok ? ram_rdata : 8'h00;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
            r_slot  <= 3'd0;
            r_init  <= 1'b1;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_slot  <= n_slot;
            r_init  <= n_init;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_data <= n_data;
    end

    assign o_init      = r_init;
    assign o_done      = r_done;
    assign o_read_data = r_data;

    // no result strobe while the power-up clearing pass runs
    a_init_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !r_done) else $error("result strobe during init clear");

    // draw writes trail their reads by one slot
    a_draw_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state == ST_DRAW) |-> (r_slot != 3'd0))
        else $error("draw write without a prior read");

    // a read always ends in a result strobe
    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RDWAIT) |=> r_done) else $error("read lost its result");

    // a working command leaves idle right after its pop
    a_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd.op != REQ_NONE) |=> (r_state != ST_IDLE))
        else $error("popped command not started");

endmodule

// ===== design/tiny_font_framebuffer_renderer.sv =====
// tiny_font_framebuffer_renderer: top level of the 3x5 font framebuffer renderer
// holds front, command queue and back; depends on tffr_pkg, tffr_front,
// tffr_queue, tffr_back
//
// back work per command: a draw is a pop and then 7 pipelined
//   read-modify-write slots over the six column/page bytes of one glyph,
//   a read a pop and then the READ and RDWAIT states, an unused request its
//   pop only, a clear a pop and a sweep of DEPTH = DISPLAY_WIDTH * pages bytes
//   (one store byte written per cycle); a queued command waits until the back is idle
// reset: a clearing pass over all DEPTH store bytes (512 at defaults) blanks
//   the store, busy stays high through it; mirror_enable resets to 1
// results cannot be stalled: o_done is high one cycle per transfer
module tiny_font_framebuffer_renderer #(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command channel: transfer when start is high and busy is low
    input  logic              start,
    output logic              busy,
    // mirror_enable register
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    // request fields
    input  logic [1:0]        i_req_type,
    input  logic [7:0]        i_char_code,
    input  logic signed [8:0] i_pos_x,
    input  logic signed [5:0] i_pos_y,
    input  logic [1:0]        i_read_page,
    input  logic [6:0]        i_read_column,
    // result: one per request, valid for exactly one cycle
    output logic              o_done,
    output logic [7:0]        o_read_data
);
    import tffr_pkg::*;

    t_cmd    front_cmd;
    t_cmd    queue_cmd;
    t_q_stat q_stat;
    logic    push;
    logic    pop;
    logic    init;

    // front: decodes the request, looks up the glyph, applies mirroring
    // to the read column, and pushes one command per transfer
    tffr_front #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_type    (i_req_type),
        .i_char_code   (i_char_code),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_read_page   (i_read_page),
        .i_read_column (i_read_column),
        .i_q_stat      (q_stat),
        .i_init        (init),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    // two entry queue so the front keeps taking requests while a draw
    // or clear is still running in the back
    tffr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_stat  (q_stat)
    );

    // back: owns the frame store ram and produces the result strobe
    tffr_back #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_init      (init),
        .o_done      (o_done),
        .o_read_data (o_read_data)
    );

endmodule
